>>> hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Action codes and the control bundle between the top level and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    // action codes
    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_CMP = 3'd4;

    // divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

>>> hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact add, subtract, multiply, divide, compare
// Cross-multiplies signed fractions, reduces by gcd, positive denominator.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_stall  | action, a_num, a_den, b_num, b_den
//  out     | output    | o_valid / i_stall  | res_num, res_den, less, equal,
//          |           |                    | overflow, error
//
// One request at a time. After acceptance: the products and the signed combine,
// then Euclid steps on the shared bit-serial divider (data dependent count),
// then the two final divides on the same divider, then the output register is
// loaded. Error requests go straight to the output state.
// Reset is synchronous and clears the sequencer and o_valid. A result waits in
// the output register while i_stall is high; the next request may be taken
// meanwhile, and the sequencer holds its result until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [2:0]  i_action,
    input  wire  signed [31:0] i_a_num,
    input  wire  signed [31:0] i_a_den,
    input  wire  signed [31:0] i_b_num,
    input  wire  signed [31:0] i_b_den,
    output logic        o_valid,
    input  wire         i_stall,
    output logic signed [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic        o_less,
    output logic        o_equal,
    output logic        o_overflow,
    output logic        o_error
);

    localparam int W  = WORD_BITS;
    localparam int DW = 2 * WORD_BITS;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL1  = 10'b0000000010,
        S_MUL2  = 10'b0000000100,
        S_COMB  = 10'b0000001000,
        S_GCD   = 10'b0000010000,
        S_GWAIT = 10'b0000100000,
        S_DIVN  = 10'b0001000000,
        S_DIVD  = 10'b0010000000,
        S_DWAIT = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;

    logic [2:0]    r_act;
    logic [31:0]   r_a_num, r_a_den;
    logic          r_sa, r_sb;
    logic [W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic [DW-1:0] r_p0, r_p1, r_p2;
    logic [DW-1:0] r_rn, r_rd, r_gx, r_gy, r_qn;
    logic          r_rs;
    logic [31:0]   r_res_num;
    logic [30:0]   r_res_den;
    logic          r_less, r_equal, r_ovf, r_err;

    // magnitude of a WORD_BITS two's complement field
    function automatic logic [W-1:0] mag(input logic [31:0] v);
        logic [W-1:0] x;
        x = v[W-1:0];
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    // operand decode
    logic [W-1:0] w_an, w_ad, w_bn, w_bd;
    logic         w_sa, w_sb, w_bad;
    assign w_an = mag(i_a_num);
    assign w_ad = mag(i_a_den);
    assign w_bn = mag(i_b_num);
    assign w_bd = mag(i_b_den);
    assign w_sa = (i_a_num[W-1] != i_a_den[W-1]) && (w_an != '0);
    assign w_sb = (i_b_num[W-1] != i_b_den[W-1]) && (w_bn != '0);
    assign w_bad = (i_action > ACT_CMP) || (w_ad == '0) || (w_bd == '0)
                   || ((i_action == ACT_DIV) && (w_bn == '0));

    // shared divider
    t_div_ctl      w_dctl;
    t_div_sts      w_dsts;
    logic [DW-1:0] w_dnd, w_dvs, w_quot, w_rem;

    rau_divider #(.WIDTH(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_dctl),
        .i_dividend (w_dnd),
        .i_divisor  (w_dvs),
        .o_sts      (w_dsts),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        w_dctl.start = 1'b0;
        w_dnd = r_gx;
        w_dvs = r_gy;
        case (r_state)
            S_GCD: w_dctl.start = 1'b1;
            S_DIVN: begin
                w_dctl.start = 1'b1;
                w_dnd = r_rn;
                w_dvs = r_gx;
            end
            S_DIVD: begin
                // denominator divide starts as the numerator quotient lands
                w_dctl.start = w_dsts.done;
                w_dnd = r_rd;
                w_dvs = r_gx;
            end
            default: w_dctl.start = 1'b0;
        endcase
    end

    // signed combine of the cross products
    logic          w_sbe, w_rs;
    logic [DW-1:0] w_rn;
    always_comb begin
        w_sbe = (r_act == ACT_SUB) ? (!r_sb && r_bn != '0) : r_sb;
        w_rs  = 1'b0;
        w_rn  = r_p0;
        if (r_act == ACT_ADD || r_act == ACT_SUB) begin
            if (r_sa == w_sbe) begin
                w_rs = r_sa;
                w_rn = r_p0 + r_p1;
            end else if (r_p0 >= r_p1) begin
                w_rs = r_sa;
                w_rn = r_p0 - r_p1;
            end else begin
                w_rs = w_sbe;
                w_rn = r_p1 - r_p0;
            end
        end else begin
            w_rs = r_sa != r_sb;
        end
        if (w_rn == '0) w_rs = 1'b0;
    end

    // compare flags from the cross products
    logic w_eq, w_lt;
    assign w_eq = (r_sa == r_sb) && (r_p0 == r_p1);
    assign w_lt = !w_eq && ((r_sa != r_sb) ? r_sa
                                           : (r_sa ? (r_p0 > r_p1) : (r_p0 < r_p1)));

    // range check on the reduced result
    logic [DW-1:0] w_half;
    logic          w_ovf;
    assign w_half = DW'(1) << (W - 1);
    assign w_ovf  = (w_quot > w_half - 1'b1)
                    || (r_rs ? (r_qn > w_half) : (r_qn > w_half - 1'b1));

    logic [DW-1:0] w_neg;
    assign w_neg = r_rs ? (~r_qn + 1'b1) : r_qn;

    // output register free when empty or being taken
    logic w_out_free;
    assign w_out_free = !o_valid || !i_stall;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_act   <= i_action;
                    r_a_num <= i_a_num;
                    r_a_den <= i_a_den;
                    r_an <= w_an; r_ad <= w_ad; r_bn <= w_bn; r_bd <= w_bd;
                    r_sa <= w_sa; r_sb <= w_sb;
                    r_res_num <= '0; r_res_den <= 31'd1;
                    r_less <= 1'b0; r_equal <= 1'b0;
                    r_ovf <= 1'b0; r_err <= w_bad;
                    if (w_bad) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    // cross products, one multiplier each per cycle
                    r_p0 <= DW'(r_an) * DW'(r_bd);
                    r_p1 <= DW'(r_bn) * DW'(r_ad);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    if (r_act == ACT_MUL) begin
                        r_p0 <= DW'(r_an) * DW'(r_bn);
                        r_p2 <= DW'(r_ad) * DW'(r_bd);
                    end else if (r_act == ACT_DIV) begin
                        r_p2 <= DW'(r_ad) * DW'(r_bn);
                    end else begin
                        r_p2 <= DW'(r_ad) * DW'(r_bd);
                    end
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    if (r_act == ACT_CMP) begin
                        r_equal <= w_eq;
                        r_less  <= w_lt;
                        r_state <= S_OUT;
                    end else if (w_rn == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_rn <= w_rn;
                        r_rs <= w_rs;
                        r_rd <= r_p2;
                        r_gx <= w_rn;
                        r_gy <= r_p2;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: r_state <= S_GWAIT;
                S_GWAIT: if (w_dsts.done) begin
                    // one Euclid step
                    if (w_rem == '0) begin
                        r_gx <= r_gy;
                        r_state <= S_DIVN;
                    end else begin
                        r_gx <= r_gy;
                        r_gy <= w_rem;
                        r_state <= S_GCD;
                    end
                end
                S_DIVN: r_state <= S_DIVD;
                S_DIVD: if (w_dsts.done) begin
                    r_qn <= w_quot;
                    r_state <= S_DWAIT;
                end
                S_DWAIT: if (w_dsts.done) begin
                    if (w_ovf) begin
                        r_ovf     <= 1'b1;
                        r_res_num <= r_a_num;
                        r_res_den <= r_a_den[30:0];
                    end else begin
                        r_res_num <= 32'(signed'(w_neg[W-1:0]));
                        r_res_den <= 31'(w_quot);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (w_out_free) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            o_valid    <= 1'b1;
            o_res_num  <= r_res_num;
            o_res_den  <= r_res_den;
            o_less     <= r_less;
            o_equal    <= r_equal;
            o_overflow <= r_ovf;
            o_error    <= r_err;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> hdl/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider: restoring divider, one quotient bit per cycle
// Gives quotient and remainder of two unsigned words.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_divider
    import rau_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_div_ctl         i_ctl,
    input  wire [WIDTH-1:0]  i_dividend,
    input  wire [WIDTH-1:0]  i_divisor,
    output t_div_sts         o_sts,
    output logic [WIDTH-1:0] o_quot,
    output logic [WIDTH-1:0] o_rem
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_q, r_d;
    logic [WIDTH:0]   r_r;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [WIDTH:0]   w_sh, w_diff;

    // shift in the next dividend bit and trial-subtract
    assign w_sh   = {r_r[WIDTH-1:0], r_q[WIDTH-1]};
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q <= i_dividend;
            r_d <= i_divisor;
            r_r <= '0;
        end else if (r_busy) begin
            if (!w_diff[WIDTH]) begin
                r_r <= w_diff;
                r_q <= {r_q[WIDTH-2:0], 1'b1};
            end else begin
                r_r <= w_sh;
                r_q <= {r_q[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_quot     = r_q;
    assign o_rem      = r_r[WIDTH-1:0];

endmodule

`default_nettype wire
